@@ rtl/cbs_pkg.sv @@
// Package with shared constants of the B-spline evaluator.
`default_nettype none
package cbs_pkg;
	localparam int MAX_POINTS_DEF  = 1024;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int T_FRAC_BITS_DEF = 16;
	localparam int CNT_W           = 11;
	localparam int T_W             = 17;
	localparam int IDX_W           = 10;
	localparam int IO_W            = 32;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_POS   = 2'd1;
	localparam logic [1:0] FUNC_SLOPE = 2'd2;
	localparam logic [1:0] FUNC_NOP   = 2'd3;
endpackage
`default_nettype wire

@@ rtl/cbs_ram.sv @@
// Generic single write port, single registered read port RAM.
`default_nettype none
module cbs_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/cbs_front.sv @@
// Front end: accepts items, holds off loads and works out the segment and fraction.
`default_nettype none
module cbs_front #(
	parameter int MAX_POINTS  = 1024,
	parameter int T_FRAC_BITS = 16,
	parameter int SEL_W       = $clog2(MAX_POINTS)
) (
	input  wire logic [cbs_pkg::CNT_W-1:0]   cnt_raw,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  func,
	input  wire logic [cbs_pkg::T_W-1:0]     t_value,
	input  wire logic                        ld_ok,
	output logic                             q_push,
	input  wire logic                        q_full,
	output logic [SEL_W-1:0]                 q_seg,
	output logic [SEL_W-1:0]                 q_last,
	output logic                             q_segn,
	output logic [T_FRAC_BITS-1:0]           q_u,
	output logic                             q_slope
);
	import cbs_pkg::*;
	localparam int NW = SEL_W + 1;
	localparam int SW = T_FRAC_BITS + NW + 1;

	logic [NW-1:0]          n;
	logic [T_FRAC_BITS:0]   t_sat;
	logic [SW-1:0]          s;
	logic                   eval;

	// Clamp the count and the parameter, then scale.
	always_comb begin
		if (cnt_raw == '0)
			n = NW'(1);
		else if (32'(cnt_raw) > MAX_POINTS)
			n = NW'(MAX_POINTS);
		else
			n = NW'(cnt_raw);
		if (32'(t_value) > (32'(1) << T_FRAC_BITS))
			t_sat = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;
		else
			t_sat = (T_FRAC_BITS+1)'(t_value);
		s = SW'(t_sat) * SW'(n);
	end

	// A load waits until every queued evaluation has read the store.
	assign eval     = (func == FUNC_POS) || (func == FUNC_SLOPE);
	assign in_ready = !q_full && ((func != FUNC_LOAD) || ld_ok);
	assign q_push   = in_valid && in_ready && eval;
	assign q_seg    = SEL_W'(s >> T_FRAC_BITS);
	assign q_segn   = (NW'(s >> T_FRAC_BITS) == n);
	assign q_last   = SEL_W'(n - NW'(1));
	assign q_u      = s[T_FRAC_BITS-1:0];
	assign q_slope  = (func == FUNC_SLOPE);
endmodule
`default_nettype wire

@@ rtl/cbs_back.sv @@
// Back end: gathers four points, evaluates the basis polynomial and rounds.
`default_nettype none
module cbs_back #(
	parameter int MAX_POINTS  = 1024,
	parameter int COORD_WIDTH = 32,
	parameter int T_FRAC_BITS = 16,
	parameter int SEL_W       = $clog2(MAX_POINTS)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       ld_we,
	input  wire logic [SEL_W-1:0]           ld_addr,
	input  wire logic [3*COORD_WIDTH-1:0]   ld_data,
	input  wire logic                       q_valid,
	output logic                            q_pop,
	input  wire logic [SEL_W-1:0]           q_seg,
	input  wire logic [SEL_W-1:0]           q_last,
	input  wire logic                       q_segn,
	input  wire logic [T_FRAC_BITS-1:0]     q_u,
	input  wire logic                       q_slope,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [cbs_pkg::IO_W-1:0]        out_x,
	output logic [cbs_pkg::IO_W-1:0]        out_y,
	output logic [cbs_pkg::IO_W-1:0]        out_z,
	output logic                            is_slope
);
	import cbs_pkg::*;
	localparam int CW = COORD_WIDTH;
	localparam int F  = T_FRAC_BITS;
	localparam int AW = CW + 6;   // polynomial terms and sums
	localparam int PW = AW + F + 1;
	localparam int NST = 7;
	// Division by six: halve, then divide by three in two chunks by reciprocals.
	localparam int YW = AW - 1;
	localparam int H  = YW / 2;
	localparam int LO = YW - H;
	localparam logic [63:0] M1 = ((64'd1 << (H + 1)) + 64'd2) / 64'd3;
	localparam logic [63:0] M2 = ((64'd1 << (LO + 3)) + 64'd2) / 64'd3;
	localparam logic [AW-1:0] MAXV = AW'((64'd1 << (CW - 1)) - 64'd1);

	// Pipeline: s1 read, s2 coefficients, s3..s5 Horner steps, s6 and s7 divide and saturate.
	logic [NST:1] v_q;
	logic         adv;
	assign adv   = !v_q[NST] || out_ready;
	assign q_pop = q_valid && adv;

	// Four gather addresses with clamping.
	logic [SEL_W-1:0] sel [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic signed [SEL_W+2:0] x;
			x = $signed({3'b000, q_seg}) - (SEL_W+3)'(1) + (SEL_W+3)'(k);
			if (q_segn)
				sel[k] = q_last;
			else if (x <= 0)
				sel[k] = '0;
			else if (x >= $signed({3'b000, q_last}) + (SEL_W+3)'(1))
				sel[k] = q_last;
			else
				sel[k] = x[SEL_W-1:0];
		end
	end

	logic [3*CW-1:0] rd [4];
	for (genvar k = 0; k < 4; k++) begin : g_ram
		cbs_ram #(.WIDTH(3*CW), .DEPTH(MAX_POINTS)) u_ram (
			.clk(clk), .we(ld_we), .waddr(ld_addr), .wdata(ld_data),
			.re(adv), .raddr(sel[k]), .rdata(rd[k]));
	end

	logic [F-1:0] u_s1, u_s2, u_s3, u_s4;
	logic         sl_s1, sl_s2, sl_s3, sl_s4, sl_s5, sl_s6;

	// Rounded product of a term by u.
	function automatic logic signed [AW-1:0] mulf(input logic signed [AW-1:0] v,
	                                                input logic [F-1:0] u);
		logic signed [PW-1:0] p;
		logic [PW-1:0]        m;
		logic                 ng;
		ng = v[AW-1];
		m  = ng ? PW'(-v) : PW'(v);
		m  = m * PW'(u) + (PW'(1) << (F-1));
		m  = m >> F;
		p  = ng ? -$signed(m) : $signed(m);
		return p[AW-1:0];
	endfunction

	logic signed [AW-1:0] a_s2 [3], b_s2 [3], c_s2 [3], d_s2 [3];
	logic signed [AW-1:0] h_s3 [3], c_s3 [3], d_s3 [3];
	logic signed [AW-1:0] h_s4 [3], d_s4 [3], h_s5 [3];
	logic [H-1:0]         qh_s6 [3];
	logic [LO+1:0]        zl_s6 [3];
	logic [2:0]           ng_s6;
	logic [IO_W-1:0]      o_q  [3];
	logic                 sl_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1 <= q_u;  sl_s1 <= q_slope;
			u_s2 <= u_s1; sl_s2 <= sl_s1;
			u_s3 <= u_s2; sl_s3 <= sl_s2;
			u_s4 <= u_s3; sl_s4 <= sl_s3;
			sl_s5 <= sl_s4;
			sl_s6 <= sl_s5; sl_q <= sl_s6;
			for (int c = 0; c < 3; c++) begin
				logic signed [AW-1:0] p0, p1, p2, p3, t;
				logic [AW-1:0]        mg, qm;
				logic [YW-1:0]        y;
				logic [2*H-1:0]       pq;
				logic [H-1:0]         qh, rt;
				logic [2*LO+3:0]      pz;
				logic [LO-1:0]        ql;
				p0 = AW'($signed(rd[0][c*CW +: CW]));
				p1 = AW'($signed(rd[1][c*CW +: CW]));
				p2 = AW'($signed(rd[2][c*CW +: CW]));
				p3 = AW'($signed(rd[3][c*CW +: CW]));
				a_s2[c] <= -p0 + 3*p1 - 3*p2 + p3;
				b_s2[c] <= 3*p0 - 6*p1 + 3*p2;
				c_s2[c] <= -3*p0 + 3*p2;
				d_s2[c] <= p0 + 4*p1 + p2;
				// Horner, first step.
				if (sl_s2)
					h_s3[c] <= mulf(3*a_s2[c], u_s2) + 2*b_s2[c];
				else
					h_s3[c] <= mulf(a_s2[c], u_s2) + b_s2[c];
				c_s3[c] <= c_s2[c]; d_s3[c] <= d_s2[c];
				h_s4[c] <= mulf(h_s3[c], u_s3) + c_s3[c];
				d_s4[c] <= d_s3[c];
				h_s5[c] <= sl_s4 ? h_s4[c] : mulf(h_s4[c], u_s4) + d_s4[c];
				// Rounded magnitude halved, upper chunk divided by three.
				mg = h_s5[c][AW-1] ? AW'(-h_s5[c]) : AW'(h_s5[c]);
				mg = mg + AW'(3);
				y  = mg[AW-1:1];
				pq = (2*H)'(y[YW-1:LO]) * (2*H)'(M1[H-1:0]);
				qh = H'(pq >> (H + 1));
				rt = y[YW-1:LO] - qh - qh - qh;
				qh_s6[c] <= qh;
				zl_s6[c] <= {rt[1:0], y[LO-1:0]};
				ng_s6[c] <= h_s5[c][AW-1];
				// Lower chunk divided by three, then sign and saturation.
				pz = (2*LO+4)'(zl_s6[c]) * (2*LO+4)'(M2[LO+1:0]);
				ql = LO'(pz >> (LO + 3));
				qm = AW'({qh_s6[c], ql});
				if (!ng_s6[c])
					t = (qm > MAXV) ? $signed(MAXV) : $signed(qm);
				else if (qm > MAXV + AW'(1))
					t = $signed(~MAXV);
				else
					t = -$signed(qm);
				o_q[c] <= IO_W'(t);
			end
		end
	end

	// Valid shift line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (adv)
			v_q <= {v_q[NST-1:1], q_pop};
	end

	assign out_valid = v_q[NST];
	assign out_x     = o_q[0];
	assign out_y     = o_q[1];
	assign out_z     = o_q[2];
	assign is_slope  = sl_q;

`ifndef ASSERT_OFF
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x))
		else $error("result changed while stalled");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> adv) else $error("pop without advance");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_q)) else $error("pipeline moved while stalled");
`endif
endmodule
`default_nettype wire

@@ rtl/cubic_bspline_evaluator_top.sv @@
// Top level of the uniform cubic B-spline evaluator.
// Usage:
//   The in channel (in_valid/in_ready) takes items: func 0 loads a control
//   point into the store, func 1 evaluates a position and func 2 a slope at
//   t_value. Loads and func 3 give no result.
//   The out channel (out_valid/out_ready) gives one result per evaluation.
//   Throughput is one item per cycle while the queue is not full and the
//   receiver does not stall; an accepted evaluation passes the queue, then
//   seven back-end stages, which read four RAM copies of the point store.
//   A load is held off while an evaluation still waits in the queue, so it
//   never overtakes one.
//   cfg_we/cfg_wdata set point_count; the user must write it only while the block is idle, which it does not enforce.
//   Reset clears the pipeline and sets point_count to one; store contents
//   are undefined until loaded.
//   When the receiver stalls, the whole back end holds, and in_ready falls
//   as soon as the front can no longer hand items over.
`default_nettype none
module cubic_bspline_evaluator_top #(
	parameter int MAX_POINTS  = cbs_pkg::MAX_POINTS_DEF,
	parameter int COORD_WIDTH = cbs_pkg::COORD_WIDTH_DEF,
	parameter int T_FRAC_BITS = cbs_pkg::T_FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [cbs_pkg::CNT_W-1:0]  cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 func,
	input  wire logic [cbs_pkg::T_W-1:0]    t_value,
	input  wire logic [cbs_pkg::IDX_W-1:0]  point_index,
	input  wire logic [cbs_pkg::IO_W-1:0]   point_x,
	input  wire logic [cbs_pkg::IO_W-1:0]   point_y,
	input  wire logic [cbs_pkg::IO_W-1:0]   point_z,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [cbs_pkg::IO_W-1:0]        out_x,
	output logic [cbs_pkg::IO_W-1:0]        out_y,
	output logic [cbs_pkg::IO_W-1:0]        out_z,
	output logic                            is_slope
);
	import cbs_pkg::*;
	localparam int SEL_W = $clog2(MAX_POINTS);

	logic [CNT_W-1:0] cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= CNT_W'(1);
		else if (cfg_we)
			cnt_q <= cfg_wdata;
	end

	logic             push, pop, full, ld_ok;
	logic [SEL_W-1:0] seg, last;
	logic             segn, slope;
	logic [T_FRAC_BITS-1:0] u;

	cbs_front #(.MAX_POINTS(MAX_POINTS), .T_FRAC_BITS(T_FRAC_BITS)) u_front (
		.cnt_raw(cnt_q), .in_valid(in_valid),
		.in_ready(in_ready), .func(func), .t_value(t_value), .ld_ok(ld_ok),
		.q_push(push), .q_full(full), .q_seg(seg), .q_last(last), .q_segn(segn),
		.q_u(u), .q_slope(slope));

	// Two-entry queue between front and back.
	localparam int QW = 2*SEL_W + 2 + T_FRAC_BITS;
	logic [QW-1:0] qd_q [2];
	logic [1:0]    qc_q;
	logic [QW-1:0] qh;
	assign full  = (qc_q == 2'd2);
	assign qh    = qd_q[0];
	// The queue is empty, or its only entry reads the store at this edge.
	assign ld_ok = (qc_q == 2'd0) || ((qc_q == 2'd1) && pop);
	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && qc_q == 2'd1)
				qd_q[0] <= {seg, last, segn, slope, u};
			else
				qd_q[0] <= qd_q[1];
			if (push && qc_q == 2'd2)
				qd_q[1] <= {seg, last, segn, slope, u};
		end else if (push)
			qd_q[qc_q[0]] <= {seg, last, segn, slope, u};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			qc_q <= '0;
		else
			qc_q <= qc_q + 2'(push) - 2'(pop);
	end

	logic ld_we;
	logic [SEL_W-1:0] ld_addr;
	assign ld_we   = in_valid && in_ready && (func == FUNC_LOAD) &&
	                 (32'(point_index) < MAX_POINTS);
	assign ld_addr = SEL_W'(point_index);

	cbs_back #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH),
	           .T_FRAC_BITS(T_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .ld_we(ld_we), .ld_addr(ld_addr),
		.ld_data({COORD_WIDTH'(point_z), COORD_WIDTH'(point_y),
		          COORD_WIDTH'(point_x)}),
		.q_valid(qc_q != 2'd0), .q_pop(pop),
		.q_seg(qh[QW-1 -: SEL_W]), .q_last(qh[QW-SEL_W-1 -: SEL_W]),
		.q_segn(qh[T_FRAC_BITS+1]), .q_u(qh[T_FRAC_BITS-1:0]),
		.q_slope(qh[T_FRAC_BITS]),
		.out_valid(out_valid), .out_ready(out_ready), .out_x(out_x),
		.out_y(out_y), .out_z(out_z), .is_slope(is_slope));

`ifndef ASSERT_OFF
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		qc_q <= 2'd2) else $error("queue count overflow");
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		qc_q == 2'd0 |-> !pop) else $error("pop from empty queue");
`endif
endmodule
`default_nettype wire

@@ verif/tb_cubic_bspline_evaluator_top.sv @@
// Self-checking testbench of the cubic B-spline evaluator with a curve prediction scoreboard.
`timescale 1ns / 100ps
`default_nettype none

// Holds its own copy of the point store and count, predicts each curve item and checks results.
class spline_scoreboard;
	longint store_x[1024];
	longint store_y[1024];
	longint store_z[1024];
	int     point_count;
	int     fail_count;
	logic [96:0] pending_curve[$];

	function new();
		point_count = 1;
		fail_count  = 0;
		foreach (store_x[k]) begin
			store_x[k] = 0;
			store_y[k] = 0;
			store_z[k] = 0;
		end
	endfunction

	// Product with the Q0.16 fraction, rounded to nearest, ties away from zero.
	function longint frac_product(longint v, longint u);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag * u + 64'sd32768) >>> 16;
		return (v < 0) ? -mag : mag;
	endfunction

	// Divide by six with rounding, then saturate to the signed 32-bit range.
	function logic [31:0] scale_down(longint v);
		longint mag;
		longint q;
		mag = (v < 0) ? -v : v;
		q = (mag + 3) / 6;
		if (v < 0)
			q = -q;
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q[31:0];
	endfunction

	function logic [31:0] blend(longint p0, longint p1, longint p2, longint p3, longint u,
			bit slope);
		longint a, b, c, d, v;
		a = -p0 + 3 * p1 - 3 * p2 + p3;
		b = 3 * p0 - 6 * p1 + 3 * p2;
		c = -3 * p0 + 3 * p2;
		d = p0 + 4 * p1 + p2;
		if (!slope) begin
			v = frac_product(a, u) + b;
			v = frac_product(v, u) + c;
			v = frac_product(v, u) + d;
		end else begin
			v = frac_product(3 * a, u) + 2 * b;
			v = frac_product(v, u) + c;
		end
		return scale_down(v);
	endfunction

	// Notes an accepted input item: loads update the store, evaluations queue a result.
	function void note_item(logic [1:0] func, logic [16:0] t, logic [9:0] idx,
			logic [31:0] x, logic [31:0] y, logic [31:0] z);
		longint n, tt, s, seg, u, g;
		int sel[4];
		bit slope;
		if (func == cbs_pkg::FUNC_LOAD) begin
			store_x[idx] = longint'($signed(x));
			store_y[idx] = longint'($signed(y));
			store_z[idx] = longint'($signed(z));
			return;
		end
		if (func != cbs_pkg::FUNC_POS && func != cbs_pkg::FUNC_SLOPE)
			return;
		n = point_count;
		if (n == 0)
			n = 1;
		if (n > 1024)
			n = 1024;
		tt = t;
		if (tt > 65536)
			tt = 65536;
		s = tt * n;
		seg = s >>> 16;
		u = s & 65535;
		for (int k = 0; k < 4; k++) begin
			g = seg - 1 + k;
			if (g <= 0)
				sel[k] = 0;
			else if (g >= n)
				sel[k] = int'(n - 1);
			else
				sel[k] = int'(g);
		end
		slope = (func == cbs_pkg::FUNC_SLOPE);
		pending_curve.push_back({slope,
			blend(store_x[sel[0]], store_x[sel[1]], store_x[sel[2]], store_x[sel[3]], u, slope),
			blend(store_y[sel[0]], store_y[sel[1]], store_y[sel[2]], store_y[sel[3]], u, slope),
			blend(store_z[sel[0]], store_z[sel[1]], store_z[sel[2]], store_z[sel[3]], u, slope)});
	endfunction

	// Compares one result item with the oldest expected one.
	function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic slope);
		logic [96:0] e;
		if (pending_curve.size() == 0) begin
			$error("unexpected result item x=%h y=%h z=%h", x, y, z);
			fail_count++;
			return;
		end
		e = pending_curve.pop_front();
		if (e[96] !== slope) begin
			$error("is_slope: expected %0d actual %0d", e[96], slope);
			fail_count++;
		end
		if (e[95:64] !== x) begin
			$error("out_x: expected %h actual %h", e[95:64], x);
			fail_count++;
		end
		if (e[63:32] !== y) begin
			$error("out_y: expected %h actual %h", e[63:32], y);
			fail_count++;
		end
		if (e[31:0] !== z) begin
			$error("out_z: expected %h actual %h", e[31:0], z);
			fail_count++;
		end
	endfunction
endclass

module tb_cubic_bspline_evaluator_top;
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [10:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [16:0] t_value;
	logic [9:0]  point_index;
	logic [31:0] point_x, point_y, point_z;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] out_x, out_y, out_z;
	logic        is_slope;
	logic        steady;
	spline_scoreboard curve_sb;

	cubic_bspline_evaluator_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .func(func), .t_value(t_value),
		.point_index(point_index), .point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_y(out_y),
		.out_z(out_z), .is_slope(is_slope)
	);

	always #1 clk = ~clk;

	// Gap lengths: mostly none or short, a few long; none at all in steady stretches.
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function logic [31:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(logic [1:0] f, logic [16:0] t, logic [9:0] idx,
			logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		t_value     <= t;
		point_index <= idx;
		point_x     <= x;
		point_y     <= y;
		point_z     <= z;
		do @(posedge clk); while (!in_ready);
		curve_sb.note_item(f, t, idx, x, y, z);
	endtask

	// Writes the point count once the pipeline has drained.
	task automatic set_count(logic [10:0] v);
		in_valid <= 1'b0;
		while (curve_sb.pending_curve.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		curve_sb.point_count = v;
	endtask

	function logic [16:0] pick_t();
		logic [16:0] t;
		case ($urandom_range(0, 9))
			0: t = 17'd0;
			1: t = 17'd65536;
			2: t = 17'($urandom_range(65537, 131071));
			default: t = 17'($urandom_range(0, 65536));
		endcase
		// With a long curve only the filled ends of the store are visited.
		if (curve_sb.point_count > 64 && t > 17'd3904 && t < 17'd61504)
			t = ($urandom_range(0, 1) == 0) ? 17'($urandom_range(0, 3904)) :
				17'($urandom_range(61504, 65536));
		return t;
	endfunction

	// Receiver stalls at random.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat (pick_gap() + 1) @(posedge clk);
			if ($urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			curve_sb.check_result(out_x, out_y, out_z, is_slope);

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int counts[9];
		int f;
		int waited;
		counts = '{2, 4, 7, 1024, 0, 2047, 1, 37, 3};
		curve_sb    = new();
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		func        = '0;
		t_value     = '0;
		point_index = '0;
		point_x     = '0;
		point_y     = '0;
		point_z     = '0;
		steady      = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme points, t at its limits and above one, every function.
		send_item(cbs_pkg::FUNC_LOAD, 17'd0, 10'd0, 32'h7fffffff, 32'h80000000, 32'h00000000);
		send_item(cbs_pkg::FUNC_POS, 17'd0, 10'd0, 32'd0, 32'd0, 32'd0);
		send_item(cbs_pkg::FUNC_SLOPE, 17'd65536, 10'd0, 32'd0, 32'd0, 32'd0);
		send_item(cbs_pkg::FUNC_LOAD, 17'd1, 10'd1, 32'h80000000, 32'h7fffffff, 32'hffffffff);
		send_item(cbs_pkg::FUNC_LOAD, 17'd0, 10'd2, 32'h7fffffff, 32'h80000000, 32'h00010000);
		send_item(cbs_pkg::FUNC_LOAD, 17'd0, 10'd3, 32'h80000000, 32'h7fffffff, 32'hfffe0000);
		send_item(cbs_pkg::FUNC_NOP, 17'd40000, 10'd1023, 32'hffffffff, 32'hffffffff,
			32'hffffffff);
		set_count(11'd4);
		send_item(cbs_pkg::FUNC_POS, 17'd0, 10'd0, 32'd0, 32'd0, 32'd0);
		send_item(cbs_pkg::FUNC_POS, 17'd32768, 10'd0, 32'd0, 32'd0, 32'd0);
		send_item(cbs_pkg::FUNC_SLOPE, 17'd49151, 10'd0, 32'd0, 32'd0, 32'd0);
		send_item(cbs_pkg::FUNC_POS, 17'd65535, 10'd0, 32'd0, 32'd0, 32'd0);
		send_item(cbs_pkg::FUNC_SLOPE, 17'd65536, 10'd0, 32'd0, 32'd0, 32'd0);
		send_item(cbs_pkg::FUNC_POS, 17'h1ffff, 10'd0, 32'd0, 32'd0, 32'd0);
		send_item(cbs_pkg::FUNC_SLOPE, 17'd16385, 10'd0, 32'd0, 32'd0, 32'd0);

		// Fill both ends of the store, the only entries that evaluations read.
		steady = 1'b1;
		for (int k = 0; k < 128; k++)
			send_item(cbs_pkg::FUNC_LOAD, 17'($urandom), (k < 64) ? 10'(k) : 10'(k + 896),
				pick_coord(), pick_coord(), pick_coord());
		steady = 1'b0;

		// Random phases over several counts, the extremes among them.
		foreach (counts[p]) begin
			set_count(11'(counts[p]));
			for (int k = 0; k < 35; k++) begin
				if (k % 17 == 0)
					steady = ($urandom_range(0, 2) == 0);
				f = $urandom_range(0, 99);
				if (f < 20)
					send_item(cbs_pkg::FUNC_LOAD, 17'($urandom), 10'($urandom), pick_coord(),
						pick_coord(), pick_coord());
				else if (f < 25)
					send_item(cbs_pkg::FUNC_NOP, 17'($urandom), 10'($urandom), $urandom,
						$urandom, $urandom);
				else
					send_item((f < 62) ? cbs_pkg::FUNC_POS : cbs_pkg::FUNC_SLOPE, pick_t(),
						10'($urandom), $urandom, $urandom, $urandom);
			end
			steady = 1'b0;
		end
		in_valid <= 1'b0;

		// Drain and let the pipeline settle.
		waited = 0;
		while (curve_sb.pending_curve.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (curve_sb.pending_curve.size() != 0) begin
			$error("%0d result items never arrived", curve_sb.pending_curve.size());
			curve_sb.fail_count++;
		end
		if (curve_sb.fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire

@@ cubic_bspline_evaluator_top.f @@
rtl/cbs_pkg.sv
rtl/cbs_ram.sv
rtl/cbs_front.sv
rtl/cbs_back.sv
rtl/cubic_bspline_evaluator_top.sv
verif/tb_cubic_bspline_evaluator_top.sv
